// ===== src/dsas_pkg.sv =====
// Shared types, constants and match helpers for the debug string artifact scanner.
package dsas_pkg;

	localparam int COUNT_WIDTH  = 32;
	localparam int OFFSET_WIDTH = 32;
	localparam int NUM_CATS     = 5;
	localparam int WIN_DEPTH    = 18;
	localparam int PAT_BITS     = 8 * WIN_DEPTH;
	localparam int NUM_PATS     = 20;
	localparam int NUM_EXTS     = 6;
	localparam int LEN_BITS     = 5;

	localparam logic [2:0] CAT_PATH       = 3'd0;
	localparam logic [2:0] CAT_ASSERTION  = 3'd1;
	localparam logic [2:0] CAT_LOG        = 3'd2;
	localparam logic [2:0] CAT_CONSOLE    = 3'd3;
	localparam logic [2:0] CAT_CREDENTIAL = 3'd4;

	localparam logic REG_MIN_LENGTH    = 1'b0;
	localparam logic REG_EXAMPLE_LIMIT = 1'b1;

	localparam logic KIND_FINDING = 1'b0;
	localparam logic KIND_TOTAL   = 1'b1;

	typedef logic [WIN_DEPTH-1:0][7:0] win_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] string_offset;
		logic [31:0] string_length;
		logic        path_hit;
		logic        assertion_hit;
		logic        log_hit;
		logic        console_hit;
		logic        credential_hit;
		logic [4:0]  example_mask;
		logic [2:0]  category_index;
		logic [31:0] total_count;
		logic        last_result;
	} out_item_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	// Texts are right-aligned: the final character sits in the low byte.
	// An underscore is written as the octal escape \137.
	localparam logic [PAT_BITS-1:0] PAT_TEXT [NUM_PATS] = '{
		PAT_BITS'("assert failed"), PAT_BITS'("assertion failed"),
		PAT_BITS'("abort() was called"), PAT_BITS'("__assert\137func"),
		PAT_BITS'("[debug]"), PAT_BITS'("debug:"), PAT_BITS'("verbose:"),
		PAT_BITS'("esp\137logv"), PAT_BITS'("log\137local\137level"),
		PAT_BITS'("esp\137console"), PAT_BITS'("debug shell"), PAT_BITS'("uart console"),
		PAT_BITS'("console command"), PAT_BITS'("shell command"),
		PAT_BITS'("admin:admin"), PAT_BITS'("root:root"), PAT_BITS'("test:test"),
		PAT_BITS'("admin/admin"), PAT_BITS'("default\137password"),
		PAT_BITS'("test\137password")
	};

	localparam logic [LEN_BITS-1:0] PAT_LEN [NUM_PATS] = '{
		5'd13, 5'd16, 5'd18, 5'd13, 5'd7, 5'd6, 5'd8, 5'd8, 5'd15, 5'd11,
		5'd11, 5'd12, 5'd15, 5'd13, 5'd11, 5'd9, 5'd9, 5'd11, 5'd16, 5'd13
	};

	localparam logic [2:0] PAT_CAT [NUM_PATS] = '{
		CAT_ASSERTION, CAT_ASSERTION, CAT_ASSERTION, CAT_ASSERTION,
		CAT_LOG, CAT_LOG, CAT_LOG, CAT_LOG, CAT_LOG,
		CAT_CONSOLE, CAT_CONSOLE, CAT_CONSOLE, CAT_CONSOLE, CAT_CONSOLE,
		CAT_CREDENTIAL, CAT_CREDENTIAL, CAT_CREDENTIAL, CAT_CREDENTIAL,
		CAT_CREDENTIAL, CAT_CREDENTIAL
	};

	localparam logic [PAT_BITS-1:0] EXT_TEXT [NUM_EXTS] = '{
		PAT_BITS'(".c"), PAT_BITS'(".h"), PAT_BITS'(".cc"),
		PAT_BITS'(".cpp"), PAT_BITS'(".cxx"), PAT_BITS'(".s")
	};

	localparam logic [LEN_BITS-1:0] EXT_LEN [NUM_EXTS] = '{
		5'd2, 5'd2, 5'd3, 5'd4, 5'd4, 5'd2
	};

	// The window is zero past the run, and no text holds a zero byte, so a
	// text longer than the run never matches.
	function automatic logic ends_with(win_t w, logic [PAT_BITS-1:0] p,
			logic [LEN_BITS-1:0] len);
		logic hit;
		hit = 1'b1;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			if (LEN_BITS'(i) < len && w[i] != p[8*i +: 8]) begin
				hit = 1'b0;
			end
		end
		return hit;
	endfunction

	function automatic logic ends_with_ext(win_t w);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < NUM_EXTS; k++) begin
			if (ends_with(w, EXT_TEXT[k], EXT_LEN[k])) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

// ===== src/dsas_cell.sv =====
// One byte cell of the folded character window.
module dsas_cell import dsas_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic [7:0] d,
	output logic [7:0] q
);

	logic [7:0] byte_q;

	// Clearing a run wins over shifting in a new byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= 8'h00;
		end else if (ctl.clear) begin
			byte_q <= 8'h00;
		end else if (ctl.shift) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

// ===== src/dsas_match.sv =====
// Pattern matcher over the window: one flag per category that ends at the newest byte.
module dsas_match import dsas_pkg::*; (
	input  win_t                win,
	output logic [NUM_CATS-1:0] cats
);

	// The path category is decided elsewhere, so bit zero stays low here.
	always_comb begin
		cats = '0;
		for (int k = 0; k < NUM_PATS; k++) begin
			if (ends_with(win, PAT_TEXT[k], PAT_LEN[k])) begin
				cats[PAT_CAT[k]] = 1'b1;
			end
		end
	end

endmodule

// ===== src/debug_string_artifact_scanner_unit.sv =====
// Top level of the debug string artifact scanner: run tracking, counters and result sequencing.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    in_data    (byte_value, last_byte)
//   out       output     out_valid/out_ready  out_data   (finding or category total)
//   cfg       input      cfg_write            cfg_index, cfg_data
//
// A byte is scanned in the cycle its request is accepted; the window cells, run state and
// category counters update at that edge, so bytes that cause no result flow at one per cycle.
// A byte's results (at most one finding, plus five totals on the last byte) wait in a
// result stage and leave through the output register at one per cycle while the output is ready.
// A new request is taken whenever the result stage is empty or hands its final result over
// in that same cycle; so a byte with more than one result holds the input, stalled, until
// the result stage hands over its final result.
// Reset clears the window, run state, counters, configuration to 4 and 5, and all valids.
// A stalled output holds its register; the result stage and then the input back up behind it.
module debug_string_artifact_scanner_unit import dsas_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_write,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	localparam logic [2:0] LAST_CAT = 3'(NUM_CATS - 1);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	// Configuration registers.
	logic [7:0] min_len_q;
	logic [7:0] limit_q;

	// Run state.
	logic [OFFSET_WIDTH-1:0] pos_q;
	logic [OFFSET_WIDTH-1:0] start_q;
	logic [31:0]             len_q;
	logic [NUM_CATS-1:0]     flags_q;
	logic                    sep_q;
	logic                    pend_q;
	logic [COUNT_WIDTH-1:0]  cnt_q [NUM_CATS];

	// Result stage.
	logic                   fnd_v_s1;
	logic                   tot_v_s1;
	logic [2:0]             idx_s1;
	out_item_t              fnd_s1;
	logic [COUNT_WIDTH-1:0] tot_s1 [NUM_CATS];

	// Output register.
	logic      out_valid_q;
	out_item_t out_q;

	win_t       win;
	win_t       win_shift;
	cell_ctl_t  cell_ctl;
	logic [7:0] c;
	logic [7:0] c_fold;
	logic       in_fire;
	logic       printable;
	logic       is_term;
	logic       is_sep;
	logic       close_run;
	logic       qualify;
	logic       ext_close;

	logic [OFFSET_WIDTH-1:0] start_n;
	logic [31:0]             len_n;
	logic [NUM_CATS-1:0]     flags_n;
	logic [NUM_CATS-1:0]     new_cats;
	logic [NUM_CATS-1:0]     fin_flags;
	logic [4:0]              mask;
	logic                    sep_n;
	logic                    pend_n;
	logic [COUNT_WIDTH-1:0]  cnt_upd [NUM_CATS];

	logic      s1_busy;
	logic      load;
	logic      final_item;
	out_item_t next_out;

	assign in_fire   = in_valid && in_ready;
	assign c         = in_data.byte_value;
	assign printable = (c >= 8'h20) && (c <= 8'h7e);
	// Upper-case letters fold to lower case by setting bit five.
	assign c_fold    = (c >= 8'h41 && c <= 8'h5a) ? (c | 8'h20) : c;
	assign is_term   = (c == 8'h3a) || (c == 8'h29) || (c == 8'h20);
	assign is_sep    = (c == 8'h2f) || (c == 8'h5c);

	// The window after the new byte enters, as the cells will hold it.
	assign win_shift = {win[WIN_DEPTH-2:0], c_fold};

	genvar gi;
	generate
		for (gi = 0; gi < WIN_DEPTH; gi++) begin : g_cell
			dsas_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (cell_ctl),
				.d      (gi == 0 ? c_fold : win[(gi == 0) ? 0 : gi - 1]),
				.q      (win[gi])
			);
		end
	endgenerate

	dsas_match u_match (
		.win  (win_shift),
		.cats (new_cats)
	);

	// Next run state, as if the byte were taken.
	always_comb begin
		start_n = start_q;
		len_n   = len_q;
		flags_n = flags_q;
		sep_n   = sep_q;
		pend_n  = pend_q;
		if (printable) begin
			if (is_term && ends_with_ext(win)) begin
				pend_n = 1'b1;
			end
			if (len_q == '0) begin
				start_n = pos_q;
			end
			if (len_q != '1) begin
				len_n = len_q + 32'd1;
			end
			if (is_sep) begin
				sep_n = 1'b1;
			end
			flags_n = flags_q | new_cats;
		end
	end

	// A run closes on a non-printable byte, or on a printable last byte that joins it.
	assign close_run = (!printable && len_q != '0) || (printable && in_data.last_byte);
	assign ext_close = printable ? ends_with_ext(win_shift) : ends_with_ext(win);
	assign qualify   = close_run && (len_n != '0) && (len_n >= 32'(min_len_q));

	always_comb begin
		fin_flags = flags_n;
		if (sep_n && (pend_n || ext_close)) begin
			fin_flags[CAT_PATH] = 1'b1;
		end
		for (int i = 0; i < NUM_CATS; i++) begin
			mask[i]    = fin_flags[i] && (cnt_q[i] < COUNT_WIDTH'(limit_q));
			cnt_upd[i] = cnt_q[i];
			if (qualify && fin_flags[i] && cnt_q[i] != COUNT_MAX) begin
				cnt_upd[i] = cnt_q[i] + COUNT_WIDTH'(1);
			end
		end
	end

	assign cell_ctl.clear = in_fire && (close_run || in_data.last_byte);
	assign cell_ctl.shift = in_fire && printable;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= 8'd4;
			limit_q   <= 8'd5;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MIN_LENGTH:    min_len_q <= cfg_data;
				REG_EXAMPLE_LIMIT: limit_q   <= cfg_data;
				default:           min_len_q <= min_len_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			flags_q <= '0;
			sep_q   <= 1'b0;
			pend_q  <= 1'b0;
			for (int i = 0; i < NUM_CATS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (in_fire) begin
			if (close_run || in_data.last_byte) begin
				start_q <= '0;
				len_q   <= '0;
				flags_q <= '0;
				sep_q   <= 1'b0;
				pend_q  <= 1'b0;
			end else begin
				start_q <= start_n;
				len_q   <= len_n;
				flags_q <= flags_n;
				sep_q   <= sep_n;
				pend_q  <= pend_n;
			end
			if (in_data.last_byte) begin
				pos_q <= '0;
				for (int i = 0; i < NUM_CATS; i++) begin
					cnt_q[i] <= '0;
				end
			end else begin
				pos_q <= pos_q + OFFSET_WIDTH'(1);
				for (int i = 0; i < NUM_CATS; i++) begin
					cnt_q[i] <= cnt_upd[i];
				end
			end
		end
	end

	// Result sequencing: the finding goes first, then totals by category.
	assign s1_busy    = fnd_v_s1 || tot_v_s1;
	assign load       = s1_busy && (!out_valid_q || out_ready);
	assign final_item = fnd_v_s1 ? !tot_v_s1 : (idx_s1 == LAST_CAT);
	assign in_ready   = !s1_busy || (load && final_item);

	always_comb begin
		next_out = '0;
		if (fnd_v_s1) begin
			next_out             = fnd_s1;
			next_out.last_result = !tot_v_s1;
		end else begin
			next_out.result_kind    = KIND_TOTAL;
			next_out.category_index = idx_s1;
			next_out.total_count    = 32'(tot_s1[idx_s1]);
			next_out.last_result    = (idx_s1 == LAST_CAT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fnd_v_s1 <= 1'b0;
			tot_v_s1 <= 1'b0;
			idx_s1   <= '0;
		end else if (in_fire) begin
			fnd_v_s1 <= qualify;
			tot_v_s1 <= in_data.last_byte;
			idx_s1   <= '0;
		end else if (load) begin
			if (fnd_v_s1) begin
				fnd_v_s1 <= 1'b0;
			end else if (idx_s1 == LAST_CAT) begin
				tot_v_s1 <= 1'b0;
			end else begin
				idx_s1 <= idx_s1 + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			fnd_s1.result_kind    <= KIND_FINDING;
			fnd_s1.string_offset  <= 32'(start_n);
			fnd_s1.string_length  <= len_n;
			fnd_s1.path_hit       <= fin_flags[CAT_PATH];
			fnd_s1.assertion_hit  <= fin_flags[CAT_ASSERTION];
			fnd_s1.log_hit        <= fin_flags[CAT_LOG];
			fnd_s1.console_hit    <= fin_flags[CAT_CONSOLE];
			fnd_s1.credential_hit <= fin_flags[CAT_CREDENTIAL];
			fnd_s1.example_mask   <= mask;
			fnd_s1.category_index <= '0;
			fnd_s1.total_count    <= '0;
			fnd_s1.last_result    <= 1'b0;
			for (int i = 0; i < NUM_CATS; i++) begin
				tot_s1[i] <= cnt_upd[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= next_out;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The last byte restarts offsets for the next image.
	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.last_byte |=> pos_q == '0)
		else $error("byte position not restarted after last byte");

	// Totals never start while a finding still waits ahead of them.
	a_finding_first: assert property (@(posedge clk) disable iff (!arst_n)
		fnd_v_s1 && tot_v_s1 |-> idx_s1 == '0)
		else $error("totals started before the finding left");

	// A finding always describes a non-empty string.
	a_finding_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.result_kind == KIND_FINDING |-> out_q.string_length != '0)
		else $error("finding with zero length");

	// The input is never taken while earlier results are still queued behind a stall.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s1_busy && !load |-> !in_ready)
		else $error("request accepted over pending results");

endmodule
